/* hw/rtl/imvn_pkg.sv */
// Shared constants, opcodes and controller/datapath interface types for the vertex normal block.
`timescale 1ns / 1ps
package imvn_pkg;

  localparam int VIDX_W   = 10;
  localparam int NVERT    = 1024;
  localparam int POS_W    = 16;
  localparam int NRM_W    = 16;
  localparam int ACC_W    = 24;
  localparam int UNIT_ONE = 16384;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Address selects for the memory ports and the per-component units.
  localparam logic [1:0] SEL_A  = 2'd0;
  localparam logic [1:0] SEL_B  = 2'd1;
  localparam logic [1:0] SEL_C  = 2'd2;
  localparam logic [1:0] SEL_VI = 2'd3;

  typedef struct packed {
    logic              latch;
    logic              wr;
    logic              pos_rd;
    logic              cap_p0;
    logic              cap_p1;
    logic              edge_e;
    logic              xprod;
    logic              vec_acc;
    logic              mag_load;
    logic              shr;
    logic              shl;
    logic              sq;
    logic              sqrt;
    logic              dinit;
    logic              dstep;
    logic              dfin;
    logic              acc_rd;
    logic              acc_wr;
    logic              clr;
    logic              zl_set;
    logic [1:0]        sel;
    logic [VIDX_W-1:0] clr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       zero;
    logic       hi;
    logic       lo;
  } dp_sts_t;

endpackage

/* hw/rtl/imvn_dp.sv */
// Datapath: position and accumulator memories, cross product, normalizer, square root and divider.
`timescale 1ns / 1ps
module imvn_dp (
  input  logic                                 clk,
  input  imvn_pkg::dp_cmd_t                    cmd,
  output imvn_pkg::dp_sts_t                    sts,
  input  logic [1:0]                           in_opcode,
  input  logic [imvn_pkg::VIDX_W-1:0]          in_vertex_index,
  input  logic signed [imvn_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [imvn_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [imvn_pkg::POS_W-1:0]    in_pos_z,
  input  logic [imvn_pkg::VIDX_W-1:0]          in_corner_a,
  input  logic [imvn_pkg::VIDX_W-1:0]          in_corner_b,
  input  logic [imvn_pkg::VIDX_W-1:0]          in_corner_c,
  output logic signed [imvn_pkg::NRM_W-1:0]    out_normal_x,
  output logic signed [imvn_pkg::NRM_W-1:0]    out_normal_y,
  output logic signed [imvn_pkg::NRM_W-1:0]    out_normal_z,
  output logic                                 out_zero_length
);
  import imvn_pkg::*;

  localparam int E_W   = POS_W + 1;
  localparam int P_W   = 2 * E_W;
  localparam int VEC_W = P_W + 1;
  localparam int NM_W  = 31;
  localparam int SS_W  = 64;
  localparam int REM_W = 48;
  localparam int Q_SH  = 15;
  localparam logic signed [ACC_W:0] ACC_HI = (ACC_W+1)'((1 << (ACC_W - 1)) - 1);
  localparam logic signed [ACC_W:0] ACC_LO = -(ACC_W+1)'(1 << (ACC_W - 1));

  logic [3*POS_W-1:0] pos_mem [NVERT];
  logic [3*ACC_W-1:0] acc_mem [NVERT];

  logic [1:0]              op_r;
  logic [VIDX_W-1:0]       vi_r, ca_r, cb_r, cc_r;
  logic [3*POS_W-1:0]      wpos_r;
  logic [3*POS_W-1:0]      pos_rd_r, p0_r, p1_r;
  logic [3*ACC_W-1:0]      acc_rd_r;
  logic signed [E_W-1:0]   e1_r [3];
  logic signed [E_W-1:0]   e2_r [3];
  logic signed [VEC_W-1:0] vec_r [3];
  logic [VEC_W-1:0]        m_r [3];
  logic                    neg_r [3];
  logic [SS_W-1:0]         ss_r, res_r, bit_r;
  logic [REM_W-1:0]        rem_r, dsh_r;
  logic [NRM_W-1:0]        q_r;
  logic signed [NRM_W-1:0] n_r [3];
  logic                    zl_r;

  logic [VIDX_W-1:0]       idx, acc_wa;
  logic [3*ACC_W-1:0]      acc_wd, acc_sum;
  logic signed [E_W-1:0]   ml, mr, nl, nr;
  logic signed [P_W-1:0]   prod1, prod2;
  logic signed [VEC_W-1:0] crs;
  logic [VEC_W-1:0]        mk;
  logic                    nk;
  logic [2*NM_W-1:0]       sqp;
  logic [SS_W-1:0]         rb;
  logic [NRM_W-1:0]        qc;
  logic signed [NRM_W-1:0] nval;

  always_comb begin
    case (cmd.sel)
      SEL_A:   idx = ca_r;
      SEL_B:   idx = cb_r;
      SEL_C:   idx = cc_r;
      default: idx = vi_r;
    endcase
    case (cmd.sel)
      SEL_B:   begin mk = m_r[1]; nk = neg_r[1]; end
      SEL_C:   begin mk = m_r[2]; nk = neg_r[2]; end
      default: begin mk = m_r[0]; nk = neg_r[0]; end
    endcase
    case (cmd.sel)
      SEL_A:   begin ml = e1_r[1]; mr = e2_r[2]; nl = e1_r[2]; nr = e2_r[1]; end
      SEL_B:   begin ml = e1_r[2]; mr = e2_r[0]; nl = e1_r[0]; nr = e2_r[2]; end
      default: begin ml = e1_r[0]; mr = e2_r[1]; nl = e1_r[1]; nr = e2_r[0]; end
    endcase
  end

  assign prod1 = ml * mr;
  assign prod2 = nl * nr;
  assign crs   = VEC_W'(prod1) - VEC_W'(prod2);
  assign sqp   = mk[NM_W-1:0] * mk[NM_W-1:0];
  assign rb    = res_r + bit_r;
  assign qc    = (q_r > NRM_W'(UNIT_ONE)) ? NRM_W'(UNIT_ONE) : q_r;
  assign nval  = nk ? -$signed(qc) : $signed(qc);

  // Saturating add of the current unit normal into one stored accumulator.
  always_comb begin
    logic signed [ACC_W:0] s;
    for (int i = 0; i < 3; i++) begin
      s = (ACC_W+1)'($signed(acc_rd_r[i*ACC_W +: ACC_W])) + (ACC_W+1)'(n_r[i]);
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      acc_sum[i*ACC_W +: ACC_W] = s[ACC_W-1:0];
    end
  end

  assign acc_wa = cmd.clr ? cmd.clr_addr : idx;
  assign acc_wd = (cmd.clr || cmd.wr) ? '0 : acc_sum;

  always_ff @(posedge clk) begin
    if (cmd.wr) pos_mem[vi_r] <= wpos_r;
    if (cmd.pos_rd) pos_rd_r <= pos_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.wr || cmd.acc_wr) acc_mem[acc_wa] <= acc_wd;
    if (cmd.acc_rd) acc_rd_r <= acc_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      vi_r   <= in_vertex_index;
      ca_r   <= in_corner_a;
      cb_r   <= in_corner_b;
      cc_r   <= in_corner_c;
      wpos_r <= {in_pos_z, in_pos_y, in_pos_x};
      zl_r   <= 1'b0;
    end
    if (cmd.cap_p0) p0_r <= pos_rd_r;
    if (cmd.cap_p1) p1_r <= pos_rd_r;
    if (cmd.edge_e) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= E_W'($signed(p1_r[i*POS_W +: POS_W]))
                 - E_W'($signed(p0_r[i*POS_W +: POS_W]));
        e2_r[i] <= E_W'($signed(pos_rd_r[i*POS_W +: POS_W]))
                 - E_W'($signed(p0_r[i*POS_W +: POS_W]));
      end
    end
    if (cmd.xprod) begin
      case (cmd.sel)
        SEL_A:   vec_r[0] <= crs;
        SEL_B:   vec_r[1] <= crs;
        default: vec_r[2] <= crs;
      endcase
    end
    if (cmd.vec_acc) begin
      for (int i = 0; i < 3; i++)
        vec_r[i] <= VEC_W'($signed(acc_rd_r[i*ACC_W +: ACC_W]));
    end
    if (cmd.mag_load) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= vec_r[i][VEC_W-1];
        m_r[i]   <= vec_r[i][VEC_W-1] ? VEC_W'(-vec_r[i]) : VEC_W'(vec_r[i]);
      end
      res_r <= '0;
      bit_r <= SS_W'(1) << (SS_W - 2);
    end
    if (cmd.shr) for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
    if (cmd.shl) for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
    if (cmd.sq) ss_r <= ((cmd.sel == SEL_A) ? '0 : ss_r) + SS_W'(sqp);
    // One step of the bit-pair square root; ss_r holds the running remainder.
    if (cmd.sqrt) begin
      if (ss_r >= rb) begin
        ss_r  <= ss_r - rb;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    // Restoring division of (m * 2^15 + L) by 2L, one quotient bit per cycle.
    if (cmd.dinit) begin
      rem_r <= (REM_W'(mk[NM_W-1:0]) << Q_SH) + REM_W'(res_r[31:0]);
      dsh_r <= REM_W'(res_r[31:0]) << (Q_SH + 1);
      q_r   <= '0;
    end
    if (cmd.dstep) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[NRM_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[NRM_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.dfin) begin
      case (cmd.sel)
        SEL_A:   n_r[0] <= nval;
        SEL_B:   n_r[1] <= nval;
        default: n_r[2] <= nval;
      endcase
    end
    if (cmd.zl_set) begin
      zl_r <= 1'b1;
      for (int i = 0; i < 3; i++) n_r[i] <= '0;
    end
  end

  always_comb begin
    sts.opcode = op_r;
    sts.zero   = 1'b1;
    sts.hi     = 1'b0;
    sts.lo     = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (m_r[i] != '0) sts.zero = 1'b0;
      if (m_r[i][VEC_W-1:NM_W] != '0) sts.hi = 1'b1;
      if (m_r[i][VEC_W-1:NM_W-1] != '0) sts.lo = 1'b0;
    end
  end

  assign out_normal_x    = n_r[0];
  assign out_normal_y    = n_r[1];
  assign out_normal_z    = n_r[2];
  assign out_zero_length = zl_r;

endmodule

/* hw/rtl/imvn_ctrl.sv */
// Controller: sequences the clearing pass and each transaction through the datapath.
`timescale 1ns / 1ps
module imvn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_opcode,
  output logic               busy,
  output logic               out_valid,
  output imvn_pkg::dp_cmd_t  cmd,
  input  imvn_pkg::dp_sts_t  sts
);
  import imvn_pkg::*;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WR    = 5'd2;
  localparam logic [4:0] S_RD0   = 5'd3;
  localparam logic [4:0] S_RD1   = 5'd4;
  localparam logic [4:0] S_RD2   = 5'd5;
  localparam logic [4:0] S_EDGE  = 5'd6;
  localparam logic [4:0] S_CROSS = 5'd7;
  localparam logic [4:0] S_RACC  = 5'd8;
  localparam logic [4:0] S_RLOAD = 5'd9;
  localparam logic [4:0] S_MLOAD = 5'd10;
  localparam logic [4:0] S_NORM  = 5'd11;
  localparam logic [4:0] S_SQ    = 5'd12;
  localparam logic [4:0] S_SQRT  = 5'd13;
  localparam logic [4:0] S_DINIT = 5'd14;
  localparam logic [4:0] S_DSTEP = 5'd15;
  localparam logic [4:0] S_DFIN  = 5'd16;
  localparam logic [4:0] S_ARD   = 5'd17;
  localparam logic [4:0] S_AWR   = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd15;

  logic [4:0]        state_r, state_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [VIDX_W-1:0] clr_r, clr_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    cmd          = '0;
    cmd.sel      = k_r;
    cmd.clr_addr = clr_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        k_nxt = SEL_A;
        if (start) begin
          cmd.latch = 1'b1;
          case (in_opcode)
            OP_WRITE: state_nxt = S_WR;
            OP_TRI:   state_nxt = S_RD0;
            OP_READ:  state_nxt = S_RACC;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        cmd.sel   = SEL_VI;
        state_nxt = S_IDLE;
      end
      S_RD0: begin
        cmd.pos_rd = 1'b1;
        cmd.sel    = SEL_A;
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        cmd.pos_rd = 1'b1;
        cmd.cap_p0 = 1'b1;
        cmd.sel    = SEL_B;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        cmd.pos_rd = 1'b1;
        cmd.cap_p1 = 1'b1;
        cmd.sel    = SEL_C;
        state_nxt  = S_EDGE;
      end
      S_EDGE: begin
        cmd.edge_e = 1'b1;
        k_nxt      = SEL_A;
        state_nxt  = S_CROSS;
      end
      S_CROSS: begin
        cmd.xprod = 1'b1;
        k_nxt     = k_r + 1'b1;
        if (k_r == SEL_C) state_nxt = S_MLOAD;
      end
      S_RACC: begin
        cmd.acc_rd = 1'b1;
        cmd.sel    = SEL_VI;
        state_nxt  = S_RLOAD;
      end
      S_RLOAD: begin
        cmd.vec_acc = 1'b1;
        state_nxt   = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.mag_load = 1'b1;
        state_nxt    = S_NORM;
      end
      // Shift the magnitudes one bit a cycle until the largest sits in [2^30, 2^31).
      S_NORM: begin
        k_nxt = SEL_A;
        if (sts.zero) begin
          if (sts.opcode == OP_READ) begin
            cmd.zl_set = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            state_nxt  = S_IDLE;
          end
        end else if (sts.hi) begin
          cmd.shr = 1'b1;
        end else if (sts.lo) begin
          cmd.shl = 1'b1;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq  = 1'b1;
        k_nxt   = k_r + 1'b1;
        cnt_nxt = '0;
        if (k_r == SEL_C) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        k_nxt    = SEL_A;
        if (cnt_r == SQRT_LAST) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.dstep = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_DFIN;
      end
      S_DFIN: begin
        cmd.dfin = 1'b1;
        if (k_r == SEL_C) begin
          k_nxt     = SEL_A;
          state_nxt = (sts.opcode == OP_TRI) ? S_ARD : S_OUT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DINIT;
        end
      end
      // Each corner gets a read then a write, so a repeated corner sees its own update.
      S_ARD: begin
        cmd.acc_rd = 1'b1;
        state_nxt  = S_AWR;
      end
      S_AWR: begin
        cmd.acc_wr = 1'b1;
        k_nxt      = k_r + 1'b1;
        state_nxt  = (k_r == SEL_C) ? S_IDLE : S_ARD;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      k_r     <= SEL_A;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held longer than one cycle");

  a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_wr |-> $past(cmd.acc_rd)) else $error("accumulator write without a read");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode != OP_NOP) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dfin |-> $past(cmd.dstep)) else $error("quotient stored before division finished");
`endif

endmodule

/* hw/rtl/indexed_mesh_vertex_normals.sv */
// Top level of the indexed-mesh vertex normal block: controller plus datapath.
`timescale 1ns / 1ps
// Usage: a transaction is taken when start is high and busy is low; the in_ ports
// carry opcode, vertex index, Q7.8 position and the three triangle corners.
// Opcode 0 stores a position and clears that vertex's accumulator.
// Opcode 1 reads three positions, forms the cross product, scales it to a Q1.14
// unit vector and adds it with saturation to each corner's accumulator. It does
// the position reads, the cross product, single-bit normalizing shifts, 3 squares,
// 32 square-root steps, a bit-serial division per component and the accumulator
// read-modify-writes through the single memory ports.
// A degenerate triangle is dropped.
// Opcode 2 reads one accumulator and runs it through the same normalizer;
// its result appears on the out_ ports for exactly one cycle with out_valid high.
// The receiver cannot stall the result.
// Opcode 3 is dropped. After reset the block sweeps all 1024 accumulators to zero,
// one per cycle, holding busy high until the sweep is done.
module indexed_mesh_vertex_normals (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_vertex_index,
  input  logic signed [imvn_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [imvn_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [imvn_pkg::POS_W-1:0] in_pos_z,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_corner_a,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_corner_b,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_corner_c,
  output logic                              out_valid,
  output logic signed [imvn_pkg::NRM_W-1:0] out_normal_x,
  output logic signed [imvn_pkg::NRM_W-1:0] out_normal_y,
  output logic signed [imvn_pkg::NRM_W-1:0] out_normal_z,
  output logic                              out_zero_length
);
  import imvn_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  imvn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  imvn_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_corner_a     (in_corner_a),
    .in_corner_b     (in_corner_b),
    .in_corner_c     (in_corner_c),
    .out_normal_x    (out_normal_x),
    .out_normal_y    (out_normal_y),
    .out_normal_z    (out_normal_z),
    .out_zero_length (out_zero_length)
  );

endmodule

/* tb/imvn_normal_checker.sv */
// Checker for the vertex normal block: predicts each read result and compares it.
`timescale 1ns / 1ps
module imvn_normal_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_vertex_index,
  input  logic signed [imvn_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [imvn_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [imvn_pkg::POS_W-1:0] in_pos_z,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_corner_a,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_corner_b,
  input  logic [imvn_pkg::VIDX_W-1:0]       in_corner_c,
  input  logic                              out_valid,
  input  logic signed [imvn_pkg::NRM_W-1:0] out_normal_x,
  input  logic signed [imvn_pkg::NRM_W-1:0] out_normal_y,
  input  logic signed [imvn_pkg::NRM_W-1:0] out_normal_z,
  input  logic                              out_zero_length,
  output int                                errors,
  output int                                pending
);
  import imvn_pkg::*;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
    logic                    zl;
  } normal_t;

  int      vert_pos [NVERT][3];
  int      vert_acc [NVERT][3];
  normal_t normals_due [$];

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scales a vector to a Q1.14 unit vector; zl is set for the zero vector.
  function automatic normal_t unit_normal(input longint cx, input longint cy,
                                          input longint cz);
    longint          c [3];
    longint unsigned m [3];
    longint unsigned mx, len, q;
    int              r [3];
    normal_t         n;
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (m[i] > mx) mx = m[i];
      r[i] = 0;
    end
    n = '0;
    if (mx == 0) begin
      n.zl = 1'b1;
      return n;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * UNIT_ONE * 2 + len) / (2 * len);
      if (q > UNIT_ONE) q = UNIT_ONE;
      r[i] = (c[i] < 0) ? -int'(q) : int'(q);
    end
    n.x = r[0][NRM_W-1:0];
    n.y = r[1][NRM_W-1:0];
    n.z = r[2][NRM_W-1:0];
    return n;
  endfunction

  function automatic void add_saturated(input int v, input normal_t n);
    longint s;
    longint hi, lo;
    hi = (64'sd1 <<< (ACC_W - 1)) - 1;
    lo = -(64'sd1 <<< (ACC_W - 1));
    for (int i = 0; i < 3; i++) begin
      s = vert_acc[v][i] + ((i == 0) ? n.x : (i == 1) ? n.y : n.z);
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      vert_acc[v][i] = int'(s);
    end
  endfunction

  task automatic apply_transaction();
    int      a, b, c;
    longint  e1 [3];
    longint  e2 [3];
    normal_t n;
    case (in_opcode)
      OP_WRITE: begin
        vert_pos[in_vertex_index][0] = in_pos_x;
        vert_pos[in_vertex_index][1] = in_pos_y;
        vert_pos[in_vertex_index][2] = in_pos_z;
        for (int i = 0; i < 3; i++) vert_acc[in_vertex_index][i] = 0;
      end
      OP_TRI: begin
        a = in_corner_a; b = in_corner_b; c = in_corner_c;
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(vert_pos[b][i]) - vert_pos[a][i];
          e2[i] = longint'(vert_pos[c][i]) - vert_pos[a][i];
        end
        n = unit_normal(e1[1] * e2[2] - e1[2] * e2[1],
                        e1[2] * e2[0] - e1[0] * e2[2],
                        e1[0] * e2[1] - e1[1] * e2[0]);
        // A degenerate triangle leaves all three accumulators alone.
        if (!n.zl) begin
          add_saturated(a, n);
          add_saturated(b, n);
          add_saturated(c, n);
        end
      end
      OP_READ: begin
        normals_due.push_back(unit_normal(vert_acc[in_vertex_index][0],
                                          vert_acc[in_vertex_index][1],
                                          vert_acc[in_vertex_index][2]));
      end
      default: ;
    endcase
  endtask

  initial begin
    errors = 0;
    for (int v = 0; v < NVERT; v++)
      for (int i = 0; i < 3; i++) begin
        vert_pos[v][i] = 0;
        vert_acc[v][i] = 0;
      end
  end

  always @(posedge clk) begin
    normal_t got, want;
    if (rst_n) begin
      if (start && !busy) apply_transaction();
      if (out_valid) begin
        got = {out_normal_x, out_normal_y, out_normal_z, out_zero_length};
        if (normals_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result x=%0d y=%0d z=%0d zl=%0b",
                     got.x, got.y, got.z, got.zl);
        end else begin
          want = normals_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: normal expected x=%0d y=%0d z=%0d zl=%0b,",
                       want.x, want.y, want.z, want.zl,
                       " got x=%0d y=%0d z=%0d zl=%0b",
                       got.x, got.y, got.z, got.zl);
          end
        end
      end
    end
    pending <= normals_due.size();
  end

endmodule

/* tb/tb_indexed_mesh_vertex_normals.sv */
// Testbench top for the vertex normal block: reset, stimulus and final verdict.
`timescale 1ns / 1ps
module tb_indexed_mesh_vertex_normals;
  import imvn_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_opcode;
  logic [VIDX_W-1:0]       in_vertex_index;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic [VIDX_W-1:0]       in_corner_a, in_corner_b, in_corner_c;
  logic                    out_valid;
  logic signed [NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic                    out_zero_length;
  int                      errors;
  int                      pending;

  bit                      written [NVERT];
  int                      written_list [$];
  bit                      no_gaps;

  indexed_mesh_vertex_normals dut (.*);

  imvn_normal_checker checker_i (.*);

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  task automatic send(input logic [1:0] op, input int vi, input int px, input int py,
                      input int pz, input int ca, input int cb, input int cc);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode       <= op;
    in_vertex_index <= VIDX_W'(vi);
    in_pos_x        <= POS_W'(px);
    in_pos_y        <= POS_W'(py);
    in_pos_z        <= POS_W'(pz);
    in_corner_a     <= VIDX_W'(ca);
    in_corner_b     <= VIDX_W'(cb);
    in_corner_c     <= VIDX_W'(cc);
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE && !written[vi]) begin
      written[vi] = 1'b1;
      written_list.push_back(vi);
    end
  endtask

  task automatic write_vertex(input int vi, input int px, input int py, input int pz);
    send(OP_WRITE, vi, px, py, pz, $urandom, $urandom, $urandom);
  endtask

  task automatic triangle(input int ca, input int cb, input int cc);
    send(OP_TRI, $urandom, $urandom, $urandom, $urandom, ca, cb, cc);
  endtask

  task automatic read_normal(input int vi);
    send(OP_READ, vi, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic int pick_vertex();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  initial begin
    #1_500_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int r, vi;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_NOP;
    in_vertex_index = '0;
    {in_pos_x, in_pos_y, in_pos_z} = '0;
    {in_corner_a, in_corner_b, in_corner_c} = '0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme positions, degenerate shapes, unused opcode, cleared accumulators.
    read_normal(7);
    write_vertex(0, 0, 0, 0);
    write_vertex(1, 32767, 0, 0);
    write_vertex(2, 0, -32768, 0);
    write_vertex(3, -32768, 32767, -32768);
    write_vertex(1023, 32767, 32767, 32767);
    write_vertex(4, 65536 / 4, -1, 1);
    triangle(0, 1, 2);
    triangle(3, 1023, 2);
    triangle(0, 0, 1);
    triangle(1, 1, 1);
    write_vertex(5, 256, 256, 256);
    triangle(0, 5, 1023);
    send(OP_NOP, 3, -1, -1, -1, 1, 2, 3);
    read_normal(0);
    read_normal(1023);
    read_normal(5);
    triangle(4, 2, 3);
    read_normal(4);
    write_vertex(0, -1, -1, -1);
    read_normal(0);
    read_normal(1);
    read_normal(3);

    // Random mix, mostly on a small set of vertices so that triangles overlap.
    for (int i = 0; i < 170; i++) begin
      if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
      r = $urandom_range(0, 99);
      vi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NVERT - 1)
                                       : $urandom_range(0, 15);
      if (r < 20) begin
        write_vertex(vi, $urandom, $urandom, $urandom);
      end else if (r < 60) begin
        triangle(pick_vertex(), pick_vertex(), pick_vertex());
      end else if (r < 92) begin
        read_normal(($urandom_range(0, 1) == 0) ? pick_vertex() : vi);
      end else begin
        send(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      end
      if (i == 85) begin
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end

    // Saturation: one triangle whose normal has equal positive x and negative y
    // parts, repeated until both components clamp at opposite limits.
    write_vertex(20, 0, 0, 0);
    write_vertex(21, 256, 256, 0);
    write_vertex(22, 0, 0, 256);
    for (int i = 0; i < 740; i++) begin
      if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
      triangle(20, 21, 22);
      if (i % 100 == 99) begin
        read_normal(20);
        read_normal(22);
      end
    end
    read_normal(21);
    read_normal(22);

    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/imvn_pkg.sv
hw/rtl/imvn_dp.sv
hw/rtl/imvn_ctrl.sv
hw/rtl/indexed_mesh_vertex_normals.sv
tb/imvn_normal_checker.sv
tb/tb_indexed_mesh_vertex_normals.sv
